// ===== src/positional_list_store_defines.svh =====
// Assertion macros shared by the positional list store RTL.
// Used by the top level; no other dependencies.
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

`ifndef SYNTH
`define PLS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PLS_ASSERT(label, clk, rst, prop, msg)
`define PLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== src/pls_pkg.sv =====
// Package for the positional list store: field widths, op and status codes,
// and the control struct sent to the cell row. No dependencies.
`timescale 1ns / 1ps

package pls_pkg;

   localparam int CAPACITY_DEF = 16;

   localparam int FUNC_W   = 2;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 5;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_READ   = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_FULL   = 2'd2
   } status_type;

   typedef logic signed [VALUE_W-1:0] value_type;

   // per-cycle command to every cell
   typedef struct packed {
      logic ins;
      logic rem;
   } cell_ctl_type;

endpackage

// ===== src/pls_ifs.sv =====
// Valid/ready channel interfaces for the positional list store.
// Depends on pls_pkg.
`timescale 1ns / 1ps

interface pls_req_if import pls_pkg::*;;
   logic                 valid;
   logic                 ready;
   func_type             func;
   logic [POS_W-1:0]     position;
   value_type            value;

   modport source (output valid, output func, output position, output value,
                   input ready);
   modport sink   (input valid, input func, input position, input value,
                   output ready);
endinterface

interface pls_rsp_if import pls_pkg::*;;
   logic                 valid;
   logic                 ready;
   status_type           status;
   value_type            read_value;
   logic [LEN_W-1:0]     length;
   logic                 empty_res;

   modport source (output valid, output status, output read_value, output length,
                   output empty_res, input ready);
   modport sink   (input valid, input status, input read_value, input length,
                   input empty_res, output ready);
endinterface

// ===== src/pls_cell.sv =====
// One list slot of the cell row: holds one entry and, on insert, takes the request value
// at its own slot or its left neighbor's data, or its right neighbor's on remove. Depends on pls_pkg.
`timescale 1ns / 1ps

module pls_cell import pls_pkg::*; #(
   parameter int INDEX = 0,
   parameter int PW    = 6
) (
   input  logic          clock,
   input  cell_ctl_type  ctl,
   input  logic [PW-1:0] slot,
   input  value_type     value,
   input  value_type     left_q,
   input  value_type     right_q,
   output value_type     q
);

   localparam logic [PW-1:0] MY_SLOT = PW'(INDEX);

   value_type data_ff;
   value_type data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.ins) begin
         if (slot == MY_SLOT) begin
            data_in = value;
         end else if (slot < MY_SLOT) begin
            data_in = left_q;
         end
      end else if (ctl.rem) begin
         if (slot <= MY_SLOT) begin
            data_in = right_q;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign q = data_ff;

endmodule

// ===== src/positional_list_store.sv =====
// Positional list store: an ordered list of up to CAPACITY signed 32-bit
// values held in a row of cells, one entry per cell. One transfer is taken
// per clock cycle: an insert or remove shifts every affected cell by one slot
// on the same edge, and a read selects the addressed cell. The result is
// registered, so it appears the cycle after the request transfer, and a new
// request is taken whenever the result register is empty or being drained.
// Depends on pls_pkg, pls_ifs, pls_cell and positional_list_store_defines.svh.
`timescale 1ns / 1ps
`include "positional_list_store_defines.svh"

module positional_list_store import pls_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   pls_req_if.sink     req_ch,
   pls_rsp_if.source   rsp_ch
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;
   localparam logic [PW-1:0] CAP_W = PW'(CAPACITY);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   status_type    status_ff;
   status_type    status_in;
   value_type     rd_value_ff;
   value_type     rd_value_in;
   logic [LEN_W-1:0] length_ff;
   logic          empty_ff;

   logic          acc;
   logic [PW-1:0] pos_w;
   logic [PW-1:0] cnt_w;
   logic [PW-1:0] slot;
   logic          pos_nonzero;
   cell_ctl_type  ctl;
   value_type     cell_q [CAPACITY];

   assign acc         = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign pos_w       = PW'(req_ch.position);
   assign cnt_w       = PW'(count_ff);
   assign slot        = pos_w - PW'(1);
   assign pos_nonzero = (pos_w != '0);

   always_comb begin
      count_in    = count_ff;
      status_in   = ST_OK;
      rd_value_in = '0;
      ctl         = '0;
      unique case (req_ch.func)
         FUNC_INSERT: begin
            if (!pos_nonzero || pos_w > cnt_w + PW'(1)) begin
               status_in = ST_BADPOS;
            end else if (cnt_w == CAP_W) begin
               status_in = ST_FULL;
            end else begin
               ctl.ins  = acc;
               count_in = count_ff + CW'(1);
            end
         end
         FUNC_READ: begin
            if (!pos_nonzero || pos_w > cnt_w) begin
               status_in = ST_BADPOS;
            end else begin
               rd_value_in = cell_q[slot[IW-1:0]];
            end
         end
         FUNC_REMOVE: begin
            if (!pos_nonzero || pos_w > cnt_w) begin
               status_in = ST_BADPOS;
            end else begin
               ctl.rem  = acc;
               count_in = count_ff - CW'(1);
            end
         end
         FUNC_CLEAR: begin
            count_in = '0;
         end
         default: begin
            status_in = ST_BADPOS;
         end
      endcase
      rsp_valid_in = acc || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (acc) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         status_ff   <= status_in;
         rd_value_ff <= rd_value_in;
         length_ff   <= LEN_W'(count_in);
         empty_ff    <= (count_in == '0);
      end
   end

   // cell row; end cells see zero beyond the edge
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      value_type left_q;
      value_type right_q;
      if (i == 0) begin : g_first
         assign left_q = '0;
      end else begin : g_left
         assign left_q = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_q = '0;
      end else begin : g_right
         assign right_q = cell_q[i+1];
      end
      pls_cell #(
         .INDEX (i),
         .PW    (PW)
      ) u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .slot    (slot),
         .value   (req_ch.value),
         .left_q  (left_q),
         .right_q (right_q),
         .q       (cell_q[i])
      );
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.read_value = rd_value_ff;
   assign rsp_ch.length     = length_ff;
   assign rsp_ch.empty_res  = empty_ff;

   `PLS_ASSERT(a_count_bound, clock, reset, (PW'(count_ff) <= CAP_W), "count above capacity")
   `PLS_ASSERT_NEXT(a_clear_empties, clock, reset, acc && req_ch.func == FUNC_CLEAR, rsp_valid_ff && count_ff == '0 && empty_ff, "clear left entries")
   `PLS_ASSERT(a_full_status, clock, reset, (rsp_valid_ff && status_ff == ST_FULL) |-> (PW'(count_ff) == CAP_W), "full status below capacity")
   `PLS_ASSERT(a_fail_zero, clock, reset, (rsp_valid_ff && status_ff != ST_OK) |-> (rd_value_ff == '0), "failed op returned data")
   `PLS_ASSERT_NEXT(a_one_shift, clock, reset, 1'b1, !($past(ctl.ins) && $past(ctl.rem)), "insert and remove together")

endmodule

// ===== sim/positional_list_store_checker.sv =====
// Scoreboard for the positional list store: watches both channels, keeps its own
// copy of the list, predicts each response and compares it field by field.
// Depends on pls_pkg and pls_ifs.
`timescale 1ns / 1ps

module positional_list_store_checker import pls_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   pls_req_if               req_mon,
   pls_rsp_if               rsp_mon,
   output int               error_count,
   output int               pending,
   output int               list_length,
   output int               results_seen,
   output int               full_seen,
   output int               badpos_seen
);

   typedef struct packed {
      status_type         status;
      value_type          read_value;
      logic [LEN_W-1:0]   length;
      logic               empty_res;
   } list_result_type;

   value_type         shadow_list [CAPACITY];
   int                shadow_count;
   list_result_type   expected_q [$];

   function automatic list_result_type predict_list_op(input func_type f,
                                                       input logic [POS_W-1:0] pos,
                                                       input value_type v);
      list_result_type r;
      int              p;
      int              i;
      r = '0;
      r.status = ST_OK;
      p = int'(pos);
      case (f)
         FUNC_INSERT: begin
            // position check wins over the full check
            if (p < 1 || p > shadow_count + 1) begin
               r.status = ST_BADPOS;
            end else if (shadow_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               for (i = shadow_count; i > p - 1; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[p-1] = v;
               shadow_count++;
            end
         end
         FUNC_READ: begin
            if (p < 1 || p > shadow_count) r.status = ST_BADPOS;
            else r.read_value = shadow_list[p-1];
         end
         FUNC_REMOVE: begin
            if (p < 1 || p > shadow_count) begin
               r.status = ST_BADPOS;
            end else begin
               for (i = p - 1; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
               shadow_count--;
            end
         end
         default: begin
            shadow_count = 0;
         end
      endcase
      r.length    = shadow_count[LEN_W-1:0];
      r.empty_res = (shadow_count == 0);
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t ERROR %s: expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      list_result_type exp_r;
      if (reset) begin
         expected_q.delete();
         shadow_count = 0;
         error_count  = 0;
         results_seen = 0;
         full_seen    = 0;
         badpos_seen  = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_q.push_back(predict_list_op(req_mon.func, req_mon.position,
                                                 req_mon.value));
         if (rsp_mon.valid && rsp_mon.ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
               $display("%0t ERROR unexpected response: expected none, got status %0d length %0d",
                        $time, rsp_mon.status, rsp_mon.length);
               error_count++;
            end else begin
               exp_r = expected_q.pop_front();
               if (exp_r.status == ST_FULL) full_seen++;
               if (exp_r.status == ST_BADPOS) badpos_seen++;
               compare_field("status", 32'(exp_r.status), 32'(rsp_mon.status));
               compare_field("read_value", exp_r.read_value, rsp_mon.read_value);
               compare_field("length", 32'(exp_r.length), 32'(rsp_mon.length));
               compare_field("empty_res", 32'(exp_r.empty_res), 32'(rsp_mon.empty_res));
            end
         end
      end
      pending     = expected_q.size();
      list_length = shadow_count;
   end

endmodule

// ===== sim/positional_list_store_test.sv =====
// Top of the positional list store testbench: clock, reset, request stimulus
// and response back-pressure. Depends on pls_pkg, pls_ifs, the RTL and the checker.
`timescale 1ns / 1ps

module positional_list_store_test;
   import pls_pkg::*;

   localparam int CAP = CAPACITY_DEF;

   logic clock;
   logic reset;

   pls_req_if req_ch ();
   pls_rsp_if rsp_ch ();

   int  error_count, pending, list_length, results_seen, full_seen, badpos_seen;
   int  items_sent;
   bit  calm;
   bit  hold_off_req;

   positional_list_store #(.CAPACITY(CAP)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   positional_list_store_checker #(.CAPACITY(CAP)) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_ch),
      .rsp_mon      (rsp_ch),
      .error_count  (error_count),
      .pending      (pending),
      .list_length  (list_length),
      .results_seen (results_seen),
      .full_seen    (full_seen),
      .badpos_seen  (badpos_seen)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("Mismatches found");
      $finish;
   end

   // response side: random stall bursts, plus one long hold-off on request
   initial begin : rsp_stall
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall_left   = 80;
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left = $urandom_range(1, 16) - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_op(input func_type f, input int pos, input value_type v);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 16);
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.func     <= f;
      req_ch.position <= pos[POS_W-1:0];
      req_ch.value    <= v;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      items_sent++;
   endtask

   function automatic value_type pick_value();
      case ($urandom_range(0, 11))
         0:       return value_type'(32'h8000_0000);
         1:       return value_type'(32'h7fff_ffff);
         2:       return '0;
         3:       return '1;
         default: return value_type'($urandom);
      endcase
   endfunction

   // mostly legal positions for the current length, some noise
   task automatic random_op(input int insert_pct);
      int       len;
      int       r;
      int       pos;
      func_type f;
      len = list_length;
      r   = $urandom_range(0, 99);
      if (r < 2) begin
         f   = FUNC_CLEAR;
         pos = $urandom_range(0, 31);
      end else if (r < 12) begin
         f   = func_type'($urandom_range(0, 2));
         pos = $urandom_range(0, 31);
      end else if ($urandom_range(0, 99) < insert_pct) begin
         f = FUNC_INSERT;
         case ($urandom_range(0, 3))
            0:       pos = 1;
            1:       pos = len + 1;
            default: pos = $urandom_range(1, len + 1);
         endcase
      end else begin
         f = ($urandom_range(0, 1) == 0) ? FUNC_READ : FUNC_REMOVE;
         case ($urandom_range(0, 3))
            0:       pos = 1;
            1:       pos = (len == 0) ? 1 : len;
            default: pos = (len == 0) ? 1 : $urandom_range(1, len);
         endcase
      end
      send_op(f, pos, pick_value());
   endtask

   initial begin : stimulus
      int n;
      int insert_pct;
      reset           = 1'b1;
      calm            = 1'b0;
      hold_off_req    = 1'b0;
      items_sent      = 0;
      req_ch.valid    = 1'b0;
      req_ch.func     = FUNC_CLEAR;
      req_ch.position = '0;
      req_ch.value    = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty list, bad positions, extreme values
      send_op(FUNC_READ,   1, '0);
      send_op(FUNC_REMOVE, 1, '0);
      send_op(FUNC_INSERT, 0, 32'sd5);
      send_op(FUNC_INSERT, 2, 32'sd5);
      send_op(FUNC_INSERT, 1, value_type'(32'h8000_0000));
      send_op(FUNC_INSERT, 2, value_type'(32'h7fff_ffff));
      send_op(FUNC_INSERT, 1, '1);
      send_op(FUNC_INSERT, 31, '0);
      send_op(FUNC_READ,   0, '0);
      send_op(FUNC_READ,   3, '0);
      send_op(FUNC_READ,   4, '0);
      send_op(FUNC_REMOVE, 2, '0);
      send_op(FUNC_READ,   2, '0);
      send_op(FUNC_CLEAR,  0, '0);
      send_op(FUNC_CLEAR,  31, '1);
      // fill to capacity, then full and precedence checks
      while (list_length < CAP)
         send_op(FUNC_INSERT, $urandom_range(1, list_length + 1), pick_value());
      send_op(FUNC_INSERT, CAP + 1, '1);
      send_op(FUNC_INSERT, CAP + 2, '1);
      send_op(FUNC_INSERT, 0, '1);
      send_op(FUNC_READ,   CAP, '0);
      send_op(FUNC_REMOVE, CAP, '0);
      send_op(FUNC_REMOVE, 1, '0);
      send_op(FUNC_READ,   CAP - 1, '0);

      insert_pct = 75;
      for (n = 0; n < 750; n++) begin
         if (n % 60 == 0) insert_pct = (insert_pct == 75) ? 30 : 75;
         calm = (n >= 650) || (n >= 300 && n < 360) || ((n / 90) % 4 == 3);
         // long response stall while requests keep coming back to back
         if (n == 300) hold_off_req = 1'b1;
         random_op(insert_pct);
      end

      req_ch.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Ran %0d requests, %0d responses checked; %0d hit a full list, %0d a bad position.",
               items_sent, results_seen, full_seen, badpos_seen);
      if (error_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
